/* rtl/dcf_pkg.sv */
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants for the double to custom float converter.
// ----------------------------------------------------------------------------
package dcf_pkg;

	localparam int DBL_W       = 64;
	localparam int FRAC_W      = 52;
	localparam int DEXP_W      = 11;
	localparam int TW_W        = 7;
	localparam int EW_W        = 6;
	localparam int MW_W        = 6;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int TW_RESET    = 32;
	localparam int EW_RESET    = 8;
	localparam int DBL_BIAS    = 1023;

	// register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_TOTAL_BITS = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_EXP_BITS   = 3'd4;

	// effective (clamped) format widths
	typedef struct packed {
		logic [TW_W-1:0] tw;
		logic [EW_W-1:0] ew;
		logic [MW_W-1:0] mw;
	} fmt_t;

endpackage

/* rtl/double_to_custom_float.sv */
// ----------------------------------------------------------------------------
// double_to_custom_float
// Converts raw binary64 words into a configurable custom float format.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry double_bits; a word is taken on a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry packed_value, overflowed and
// underflowed; a word leaves on an edge with out_valid high, out_stall low.
// Config: APB registers total_bits (0x0) and exp_bits (0x4); the user must write
// them only while the block is idle, as the block does not enforce it; pready is
// always high. Pipeline: an accepted word loads the input register, then the
// result register, which raises out_valid. Throughput: one word per cycle while
// out_stall is low, set by the single-pass conversion logic between the two
// registers.
// Stall: while out_stall holds a full result register, the input register
// keeps its word and in_stall rises once both registers are full.
// Reset: arst_n clears both valid flags and restores total_bits=32,
// exp_bits=8.
// ----------------------------------------------------------------------------
module double_to_custom_float (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dcf_pkg::PADDR_W-1:0]   paddr,
	input  logic [dcf_pkg::PDATA_W-1:0]   pwdata,
	output logic [dcf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dcf_pkg::DBL_W-1:0]     double_bits,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dcf_pkg::DBL_W-1:0]     packed_value,
	output logic                          overflowed,
	output logic                          underflowed
);

	dcf_pkg::fmt_t              fmt;
	logic                       valid_s1;
	logic [dcf_pkg::DBL_W-1:0]  dbl_s1;
	logic                       valid_s2;
	logic [dcf_pkg::DBL_W-1:0]  packed_c;
	logic                       ovf_c;
	logic                       unf_c;
	logic                       en_s1;
	logic                       en_s2;

	dcf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fmt     (fmt)
	);

	dcf_convert u_conv (
		.fmt          (fmt),
		.double_bits  (dbl_s1),
		.packed_value (packed_c),
		.overflowed   (ovf_c),
		.underflowed  (unf_c)
	);

	// stage enables
	assign en_s2    = !valid_s2 || !out_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) dbl_s1 <= double_bits;
		if (en_s2 && valid_s1) begin
			packed_value <= packed_c;
			overflowed   <= ovf_c;
			underflowed  <= unf_c;
		end
	end

	assign out_valid = valid_s2;

`ifndef SYNTH
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(overflowed && underflowed))
		else $error("overflow and underflow both set");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> valid_s2)
		else $error("stalled result dropped");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room");
`endif

endmodule

/* rtl/dcf_cfg.sv */
// ----------------------------------------------------------------------------
// dcf_cfg
// APB register file for total_bits and exp_bits, plus width clamping.
// ----------------------------------------------------------------------------
module dcf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dcf_pkg::PADDR_W-1:0]   paddr,
	input  logic [dcf_pkg::PDATA_W-1:0]   pwdata,
	output logic [dcf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output dcf_pkg::fmt_t                 fmt
);

	logic [dcf_pkg::TW_W-1:0] total_bits_q;
	logic [dcf_pkg::EW_W-1:0] exp_bits_q;
	logic [dcf_pkg::TW_W-1:0] tw_c;
	logic [dcf_pkg::TW_W-1:0] ew_lim;
	logic [dcf_pkg::EW_W-1:0] ew_c;
	logic                     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bits_q <= dcf_pkg::TW_W'(dcf_pkg::TW_RESET);
			exp_bits_q   <= dcf_pkg::EW_W'(dcf_pkg::EW_RESET);
		end else if (wr_en) begin
			if (paddr == dcf_pkg::ADDR_TOTAL_BITS) total_bits_q <= pwdata[dcf_pkg::TW_W-1:0];
			if (paddr == dcf_pkg::ADDR_EXP_BITS)   exp_bits_q   <= pwdata[dcf_pkg::EW_W-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (paddr == dcf_pkg::ADDR_TOTAL_BITS)
			prdata = dcf_pkg::PDATA_W'(total_bits_q);
		else if (paddr == dcf_pkg::ADDR_EXP_BITS)
			prdata = dcf_pkg::PDATA_W'(exp_bits_q);
	end

	// clamp widths: tw to 3..64, ew to 1..tw-2
	always_comb begin
		if (total_bits_q < 7'd3)       tw_c = 7'd3;
		else if (total_bits_q > 7'd64) tw_c = 7'd64;
		else                           tw_c = total_bits_q;
		ew_lim = tw_c - 7'd2;
		if (exp_bits_q == 6'd0)                  ew_c = 6'd1;
		else if ({1'b0, exp_bits_q} > ew_lim)    ew_c = ew_lim[dcf_pkg::EW_W-1:0];
		else                                     ew_c = exp_bits_q;
		fmt.tw = tw_c;
		fmt.ew = ew_c;
		fmt.mw = dcf_pkg::MW_W'(tw_c - {1'b0, ew_c} - 7'd1);
	end

endmodule

/* rtl/dcf_convert.sv */
// ----------------------------------------------------------------------------
// dcf_convert
// Combinational repack of one binary64 word into the custom format.
// ----------------------------------------------------------------------------
module dcf_convert (
	input  dcf_pkg::fmt_t               fmt,
	input  logic [dcf_pkg::DBL_W-1:0]   double_bits,
	output logic [dcf_pkg::DBL_W-1:0]   packed_value,
	output logic                        overflowed,
	output logic                        underflowed
);

	logic                           sgn;
	logic [dcf_pkg::DEXP_W-1:0]     dexp;
	logic [dcf_pkg::FRAC_W-1:0]     frac;
	logic [63:0]                    sign_w;
	logic [63:0]                    ones;
	logic [63:0]                    bias;
	logic [63:0]                    biased;
	logic [63:0]                    mant;
	logic [63:0]                    inf_w;

	assign sgn  = double_bits[63];
	assign dexp = double_bits[62:52];
	assign frac = double_bits[51:0];

	// field pieces
	always_comb begin
		sign_w = {63'd0, sgn} << (fmt.tw - 7'd1);
		ones   = (64'd1 << fmt.ew) - 64'd1;
		bias   = (64'd1 << (fmt.ew - 6'd1)) - 64'd1;
		biased = {53'd0, dexp} + bias - 64'(dcf_pkg::DBL_BIAS);
		if (fmt.mw >= 6'd52) mant = {12'd0, frac} << (fmt.mw - 6'd52);
		else                 mant = {12'd0, frac} >> (6'd52 - fmt.mw);
		inf_w  = sign_w | (ones << fmt.mw);
	end

	// case selection
	always_comb begin
		overflowed  = 1'b0;
		underflowed = 1'b0;
		if (dexp == '1) begin
			packed_value = (frac == '0) ? inf_w : (inf_w | (64'd1 << (fmt.mw - 6'd1)));
		end else if (dexp == '0) begin
			packed_value = sign_w;
			underflowed  = (frac != '0);
		end else if ($signed(biased) >= $signed(ones)) begin
			packed_value = inf_w;
			overflowed   = 1'b1;
		end else if ($signed(biased) <= 64'sd0) begin
			packed_value = sign_w;
			underflowed  = 1'b1;
		end else begin
			packed_value = sign_w | (biased << fmt.mw) | mant;
		end
	end

endmodule
